[sv/tss_pkg.sv]
package tss_pkg;

    localparam int CAP = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W = $clog2(CAP);
    localparam int LEN_W = $clog2(CAP + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_COUNT = 3'd3;
    localparam logic [2:0] OP_INTERSECT = 3'd4;
    localparam logic [2:0] OP_UNION = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REST_A,
        S_REST_B,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic set_mark;
        logic clr_mark;
    } cell_ctrl_t;

    function automatic idx_t first_idx(input logic [CAP-1:0] vec);
        idx_t k;
        k = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (vec[i]) begin
                k = idx_t'(i);
            end
        end
        return k;
    endfunction

endpackage

[sv/two_set_store_with_union_intersection_top.sv]
// Channel | Handshake          | Word
// in      | in_valid, in_stall | opcode, set_select, value, new_value
// out     | out_valid, out_stall | result_value, has_value, status, element_count, last
//
// Add, delete, update and count act when taken and deliver their word from the flush state.
// Intersection walks list A one entry a cycle, unless the output stalls a match,
// against all B cells at once; union then walks A and B once more.
// Reset empties both lists and clears all match marks.
// A stalled output holds the stream walk; a new command is taken only when idle.
module two_set_store_with_union_intersection_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic        set_select,
    input  logic signed [31:0] value,
    input  logic signed [31:0] new_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] result_value,
    output logic        has_value,
    output logic [1:0]  status,
    output logic [4:0]  element_count,
    output logic        last
);
    import tss_pkg::*;

    state_t state_reg, state_next;
    len_t   idx_reg, idx_next;
    len_t   len_a_reg, len_a_next;
    len_t   len_b_reg, len_b_next;
    logic   union_reg, union_next;

    logic       pend_valid_reg, pend_valid_next;
    value_t     pend_value_reg, pend_value_next;
    logic       pend_has_reg, pend_has_next;
    logic [1:0] pend_status_reg, pend_status_next;
    len_t       pend_count_reg, pend_count_next;

    logic       out_valid_reg, out_valid_next;
    value_t     out_value_reg, out_value_next;
    logic       out_has_reg, out_has_next;
    logic [1:0] out_status_reg, out_status_next;
    len_t       out_count_reg, out_count_next;
    logic       out_last_reg, out_last_next;

    cell_ctrl_t a_ctrl [CAP];
    cell_ctrl_t b_ctrl [CAP];
    value_t     a_val [CAP];
    value_t     b_val [CAP];
    logic [CAP-1:0] a_mark, b_mark, a_eq, b_eq, a_in, b_in, a_hit, b_hit;
    value_t a_wr, b_wr, b_key, cur_a, cur_b;

    logic accept, out_free, scan_done, rest_a_done, rest_b_done;
    logic sel_full, sel_any;
    len_t sel_len;
    idx_t sel_k, b_k, idx;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign idx      = idx_reg[IDX_W-1:0];
    assign cur_a    = a_val[idx];
    assign cur_b    = b_val[idx];
    assign b_key    = (state_reg == S_SCAN) ? cur_a : value;
    assign a_wr     = (opcode == OP_UPDATE) ? new_value : value;
    assign b_wr     = a_wr;

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            a_in[i] = (len_t'(i) < len_a_reg);
            b_in[i] = (len_t'(i) < len_b_reg);
        end
    end

    assign a_hit = a_eq & a_in;
    assign b_hit = b_eq & b_in & ~b_mark;

    assign sel_len  = set_select ? len_b_reg : len_a_reg;
    assign sel_full = (sel_len >= len_t'(CAP));
    assign sel_any  = set_select ? |b_hit : |a_hit;
    assign sel_k    = set_select ? first_idx(b_hit) : first_idx(a_hit);
    assign b_k      = first_idx(b_hit);

    assign scan_done   = (idx_reg >= len_a_reg);
    assign rest_a_done = (idx_reg >= len_a_reg);
    assign rest_b_done = (idx_reg >= len_b_reg);

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cells
            tss_cell u_a (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (a_ctrl[g]),
                .wr_value (a_wr),
                .nb_value (a_val[(g + 1) % CAP]),
                .key      (value),
                .value    (a_val[g]),
                .mark     (a_mark[g]),
                .eq       (a_eq[g])
            );
            tss_cell u_b (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (b_ctrl[g]),
                .wr_value (b_wr),
                .nb_value (b_val[(g + 1) % CAP]),
                .key      (b_key),
                .value    (b_val[g]),
                .mark     (b_mark[g]),
                .eq       (b_eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_INTERSECT || opcode == OP_UNION)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (opcode == OP_ADD || opcode == OP_DELETE ||
                             opcode == OP_UPDATE || opcode == OP_COUNT)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = union_reg ? S_REST_A : S_FLUSH;
                end
            end
            S_REST_A:
            begin
                if (rest_a_done)
                begin
                    state_next = S_REST_B;
                end
            end
            S_REST_B:
            begin
                if (rest_b_done)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic   emit;
        value_t emit_value;
        emit       = 1'b0;
        emit_value = '0;

        idx_next   = idx_reg;
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        union_next = union_reg;

        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        pend_has_next    = pend_has_reg;
        pend_status_next = pend_status_reg;
        pend_count_next  = pend_count_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_has_next    = out_has_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        for (int i = 0; i < CAP; i++)
        begin
            a_ctrl[i] = '0;
            b_ctrl[i] = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_valid_next  = 1'b1;
                    pend_value_next  = '0;
                    pend_has_next    = 1'b0;
                    pend_status_next = ST_OK;
                    pend_count_next  = '0;
                    idx_next         = '0;
                    union_next       = (opcode == OP_UNION);
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (sel_full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else if (set_select)
                            begin
                                b_ctrl[len_b_reg[IDX_W-1:0]].load = 1'b1;
                                len_b_next = len_b_reg + 1'b1;
                            end
                            else
                            begin
                                a_ctrl[len_a_reg[IDX_W-1:0]].load = 1'b1;
                                len_a_next = len_a_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!sel_any)
                            begin
                                pend_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    if (idx_t'(i) >= sel_k)
                                    begin
                                        a_ctrl[i].shift = !set_select;
                                        b_ctrl[i].shift = set_select;
                                    end
                                end
                                if (set_select)
                                begin
                                    len_b_next = len_b_reg - 1'b1;
                                end
                                else
                                begin
                                    len_a_next = len_a_reg - 1'b1;
                                end
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (!sel_any)
                            begin
                                pend_status_next = ST_NOT_FOUND;
                            end
                            else if (set_select)
                            begin
                                b_ctrl[sel_k].load = 1'b1;
                            end
                            else
                            begin
                                a_ctrl[sel_k].load = 1'b1;
                            end
                        end
                        OP_COUNT:
                        begin
                            pend_count_next = sel_len;
                        end
                        default:
                        begin
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    idx_next = '0;
                end
                else if (|b_hit)
                begin
                    if (out_free)
                    begin
                        emit             = 1'b1;
                        emit_value       = cur_a;
                        a_ctrl[idx].set_mark = 1'b1;
                        b_ctrl[b_k].set_mark = 1'b1;
                        idx_next         = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REST_A:
            begin
                if (rest_a_done)
                begin
                    idx_next = '0;
                end
                else if (!a_mark[idx])
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_value = cur_a;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REST_B:
            begin
                if (!rest_b_done)
                begin
                    if (!b_mark[idx])
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_value = cur_b;
                            idx_next   = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_value_next  = pend_valid_reg ? pend_value_reg : '0;
                    out_has_next    = pend_valid_reg && pend_has_reg;
                    out_status_next = pend_valid_reg ? pend_status_reg : ST_OK;
                    out_count_next  = pend_valid_reg ? pend_count_reg : '0;
                    pend_valid_next = 1'b0;
                    for (int i = 0; i < CAP; i++)
                    begin
                        a_ctrl[i].clr_mark = 1'b1;
                        b_ctrl[i].clr_mark = 1'b1;
                    end
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase

        // A streamed word is held back in the pending register so the final one can carry last.
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_last_next   = 1'b0;
                out_value_next  = pend_value_reg;
                out_has_next    = pend_has_reg;
                out_status_next = pend_status_reg;
                out_count_next  = pend_count_reg;
            end
            pend_valid_next  = 1'b1;
            pend_value_next  = emit_value;
            pend_has_next    = 1'b1;
            pend_status_next = ST_OK;
            pend_count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            len_a_reg      <= '0;
            len_b_reg      <= '0;
            union_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            len_a_reg      <= len_a_next;
            len_b_reg      <= len_b_next;
            union_reg      <= union_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg  <= pend_value_next;
        pend_has_reg    <= pend_has_next;
        pend_status_reg <= pend_status_next;
        pend_count_reg  <= pend_count_next;
        out_value_reg   <= out_value_next;
        out_has_reg     <= out_has_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = out_value_reg;
    assign has_value     = out_has_reg;
    assign status        = out_status_reg;
    assign element_count = out_count_reg;
    assign last          = out_last_reg;

endmodule

[sv/tss_cell.sv]
module tss_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tss_pkg::cell_ctrl_t ctrl,
    input  tss_pkg::value_t     wr_value,
    input  tss_pkg::value_t     nb_value,
    input  tss_pkg::value_t     key,
    output tss_pkg::value_t     value,
    output logic                mark,
    output logic                eq
);
    import tss_pkg::*;

    value_t val_reg;
    logic   mark_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            val_reg <= wr_value;
        end
        else if (ctrl.shift)
        begin
            val_reg <= nb_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else if (ctrl.clr_mark)
        begin
            mark_reg <= 1'b0;
        end
        else if (ctrl.set_mark)
        begin
            mark_reg <= 1'b1;
        end
    end

    assign value = val_reg;
    assign mark  = mark_reg;
    assign eq    = (val_reg == key);

endmodule

[tb/sv/tb_two_set_store_with_union_intersection_top.sv]
module tb_two_set_store_with_union_intersection_top;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0] rvalue;
        logic        hval;
        logic [1:0]  st;
        logic [4:0]  cnt;
        logic        lst;
    } outword_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic               set_select;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_value;
    logic               has_value;
    logic [1:0]         status;
    logic [4:0]         element_count;
    logic               last;

    value_t   store_a[CAP];
    value_t   store_b[CAP];
    int       len_a;
    int       len_b;
    outword_t pending_words[$];
    int       mismatches;
    int       words_seen;
    int       stream_words;
    int       hold_cycles;
    bit       hold_free;
    int       rx_wait;

    two_set_store_with_union_intersection_top DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .set_select(set_select), .value(value),
        .new_value(new_value), .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .has_value(has_value), .status(status),
        .element_count(element_count), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic outword_t mk(logic [31:0] v, logic h, logic [1:0] s, logic [4:0] c);
        outword_t w;
        w.rvalue = v;
        w.hval = h;
        w.st = s;
        w.cnt = c;
        w.lst = 1'b0;
        return w;
    endfunction

    task automatic predict_command(logic [2:0] op, logic sel, value_t v, value_t nv);
        outword_t words[$];
        bit       mark_a[CAP];
        bit       mark_b[CAP];
        int       k;
        int       n;
        outword_t w;
        n = sel ? len_b : len_a;
        k = -1;
        for (int i = 0; i < CAP; i++)
        begin
            mark_a[i] = 0;
            mark_b[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (k < 0 && (sel ? store_b[i] : store_a[i]) == v)
            begin
                k = i;
            end
        end
        case (op)
            OP_ADD:
            begin
                if (n >= CAP)
                begin
                    words.push_back(mk('0, 0, ST_FULL, 0));
                end
                else
                begin
                    if (sel)
                    begin
                        store_b[len_b] = v;
                        len_b++;
                    end
                    else
                    begin
                        store_a[len_a] = v;
                        len_a++;
                    end
                    words.push_back(mk('0, 0, ST_OK, 0));
                end
            end
            OP_DELETE, OP_UPDATE:
            begin
                if (k < 0)
                begin
                    words.push_back(mk('0, 0, ST_NOT_FOUND, 0));
                end
                else
                begin
                    if (op == OP_UPDATE)
                    begin
                        if (sel) store_b[k] = nv;
                        else store_a[k] = nv;
                    end
                    else
                    begin
                        for (int i = k; i + 1 < n; i++)
                        begin
                            if (sel) store_b[i] = store_b[i + 1];
                            else store_a[i] = store_a[i + 1];
                        end
                        if (sel) len_b--;
                        else len_a--;
                    end
                    words.push_back(mk('0, 0, ST_OK, 0));
                end
            end
            OP_COUNT:
            begin
                words.push_back(mk('0, 0, ST_OK, 5'(n)));
            end
            OP_INTERSECT, OP_UNION:
            begin
                for (int i = 0; i < len_a; i++)
                begin
                    for (int j = 0; j < len_b; j++)
                    begin
                        if (!mark_a[i] && !mark_b[j] && store_a[i] == store_b[j])
                        begin
                            mark_a[i] = 1;
                            mark_b[j] = 1;
                            words.push_back(mk(store_a[i], 1, ST_OK, 0));
                        end
                    end
                end
                if (op == OP_UNION)
                begin
                    for (int i = 0; i < len_a; i++)
                    begin
                        if (!mark_a[i]) words.push_back(mk(store_a[i], 1, ST_OK, 0));
                    end
                    for (int j = 0; j < len_b; j++)
                    begin
                        if (!mark_b[j]) words.push_back(mk(store_b[j], 1, ST_OK, 0));
                    end
                end
                if (words.size() == 0)
                begin
                    words.push_back(mk('0, 0, ST_OK, 0));
                end
                stream_words += words.size();
            end
            default:
            begin
            end
        endcase
        if (words.size() > 0)
        begin
            words[words.size() - 1].lst = 1'b1;
        end
        foreach (words[i])
        begin
            pending_words.push_back(words[i]);
        end
    endtask

    task automatic send_command(logic [2:0] op, logic sel, value_t v, value_t nv, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        set_select <= sel;
        value <= v;
        new_value <= nv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_command(op, sel, v, nv);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom();
            default: v = $urandom_range(0, 7);
        endcase
        return v;
    endfunction

    function automatic value_t pick_present(logic sel);
        int n;
        n = sel ? len_b : len_a;
        if (n == 0 || $urandom_range(0, 3) == 0) return pick_value();
        return sel ? store_b[$urandom_range(0, n - 1)] : store_a[$urandom_range(0, n - 1)];
    endfunction

    always @(posedge clk)
    begin
        outword_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected word: value %h has %b status %0d count %0d last %b",
                             result_value, has_value, status, element_count, last);
                end
            end
            else
            begin
                want = pending_words.pop_front();
                if (want.rvalue !== result_value || want.hval !== has_value ||
                    want.st !== status || want.cnt !== element_count || want.lst !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected %h/%b/%0d/%0d/%b got %h/%b/%0d/%0d/%b",
                                 want.rvalue, want.hval, want.st, want.cnt, want.lst,
                                 result_value, has_value, status, element_count, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int draw;
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_free)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                draw = $urandom_range(0, 19);
            end
            else
            begin
                draw = (rx_wait > 0) ? rx_wait - 1 : 0;
            end
            rx_wait <= draw;
            out_stall <= (draw > 0) ? 1'b1 : 1'b0;
        end
    end

    task automatic test_directed();
        send_command(OP_COUNT, 0, 0, 0);
        send_command(OP_INTERSECT, 0, 0, 0);
        send_command(OP_UNION, 0, 0, 0);
        send_command(OP_DELETE, 1, 5, 0);
        send_command(OP_UPDATE, 0, 5, 6);
        send_command(OP_ADD, 0, 32'h8000_0000, 0);
        send_command(OP_ADD, 0, 32'h7FFF_FFFF, 0);
        send_command(OP_ADD, 0, 3, 0);
        send_command(OP_ADD, 1, 3, 0);
        send_command(OP_ADD, 1, 32'h8000_0000, 0);
        send_command(OP_ADD, 1, 32'hFFFF_FFFF, 0);
        send_command(OP_UPDATE, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_command(OP_UPDATE, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_command(OP_INTERSECT, 0, 0, 0);
        send_command(OP_UNION, 0, 0, 0);
        send_command(OP_DELETE, 0, 3, 0);
        send_command(OP_DELETE, 0, 9, 0);
        send_command(OP_SPARE_6, 0, 1, 1);
        send_command(OP_SPARE_7, 1, 1, 1);
        send_command(OP_COUNT, 0, 0, 0);
        send_command(OP_COUNT, 1, 0, 0);
        wait_drained();
    endtask

    task automatic test_full_lists();
        for (int i = 0; i < CAP + 1; i++)
        begin
            send_command(OP_ADD, 0, $urandom_range(0, 3), 0);
            send_command(OP_ADD, 1, $urandom_range(0, 3), 0);
        end
        send_command(OP_COUNT, 1, 0, 0);
        send_command(OP_UNION, 0, 0, 0);
        send_command(OP_INTERSECT, 0, 0, 0);
        send_command(OP_DELETE, 0, store_a[CAP - 1], 0);
        send_command(OP_DELETE, 1, 32'h7FFF_FFFF, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
        begin
            send_command((i % 2) ? OP_UNION : OP_COUNT, 1'(i), 0, 0, 0);
        end
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        logic       sel;
        for (int i = 0; i < count; i++)
        begin
            sel = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: op = OP_ADD;
                5, 6: op = OP_DELETE;
                7, 8: op = OP_UPDATE;
                9: op = OP_COUNT;
                10, 11: op = OP_INTERSECT;
                12, 13: op = OP_UNION;
                14: op = OP_SPARE_6;
                default: op = ($urandom_range(0, 1)) ? OP_SPARE_7 : OP_DELETE;
            endcase
            send_command(op, sel, pick_present(sel), pick_value());
            if (i % 100 == 99)
            begin
                hold_free = 1'($urandom_range(0, 1));
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        set_select = 1'b0;
        value = '0;
        new_value = '0;
        out_stall = 1'b0;
        len_a = 0;
        len_b = 0;
        mismatches = 0;
        words_seen = 0;
        stream_words = 0;
        hold_cycles = 0;
        hold_free = 0;
        rx_wait = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_lists();
        test_backpressure();
        test_random(330);
        $display("Run covered all six commands, spare opcodes, full and empty lists, %0d words",
                 words_seen);
        $display("checked, %0d of them from union and intersection streams.", stream_words);
        if (mismatches == 0 && pending_words.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
